FILE: src/slcfr_pkg.sv
// package for the sync/length/crc-8 frame receiver
// shared types, register indexes, phase and status codes, crc constants
// no dependencies
package slcfr_pkg;

  typedef logic [7:0] byte_t;
  typedef logic [5:0] len_t;
  typedef logic [1:0] status_t;
  typedef logic [1:0] phase_t;
  typedef logic [1:0] reg_idx_t;

  // control group from the receiver into the serial crc unit
  typedef struct packed {
    logic init;   // reload the initial value
    logic start;  // fold in a new byte and run eight bit steps
  } crc_ctrl_t;

  // receiver phases
  localparam phase_t PH_SYNC1 = 2'd0;
  localparam phase_t PH_SYNC2 = 2'd1;
  localparam phase_t PH_LEN   = 2'd2;
  localparam phase_t PH_DATA  = 2'd3;

  // frame status codes
  localparam status_t ST_OK      = 2'd0;
  localparam status_t ST_CRC     = 2'd1;
  localparam status_t ST_LEN     = 2'd2;
  localparam status_t ST_TIMEOUT = 2'd3;

  // register indexes on the configuration port
  localparam reg_idx_t REG_FIRST_SYNC  = 2'd0;
  localparam reg_idx_t REG_SECOND_SYNC = 2'd1;
  localparam reg_idx_t REG_MAX_LENGTH  = 2'd2;
  localparam reg_idx_t REG_TIMEOUT_MS  = 2'd3;

  // register reset values
  localparam byte_t       FIRST_SYNC_RST  = 8'h55;
  localparam byte_t       SECOND_SYNC_RST = 8'hAA;
  localparam len_t        MAX_LENGTH_RST  = 6'd63;
  localparam logic [15:0] TIMEOUT_MS_RST  = 16'd500;

  // crc-8, msb first, no final xor
  localparam byte_t CRC_INIT = 8'hFF;
  localparam byte_t CRC_POLY = 8'h31;

  localparam logic [15:0] TICKS_MAX = 16'hFFFF;

endpackage

FILE: src/slcfr_in_if.sv
// input channel of the frame receiver: one received byte or one tick per beat
// depends on slcfr_pkg
interface slcfr_in_if;
  import slcfr_pkg::*;

  logic  valid;
  logic  ready;
  logic  operation;
  byte_t data_byte;

  modport source (output valid, output operation, output data_byte, input ready);
  modport sink   (input valid, input operation, input data_byte, output ready);
endinterface

FILE: src/slcfr_out_if.sv
// result channel of the frame receiver: payload bytes or one status beat
// depends on slcfr_pkg
interface slcfr_out_if;
  import slcfr_pkg::*;

  logic    valid;
  logic    ready;
  byte_t   payload_byte;
  len_t    byte_index;
  logic    payload_valid;
  status_t frame_status;
  logic    last;

  modport source (output valid, output payload_byte, output byte_index,
                  output payload_valid, output frame_status, output last,
                  input ready);
  modport sink   (input valid, input payload_byte, input byte_index,
                  input payload_valid, input frame_status, input last,
                  output ready);
endinterface

FILE: src/sync_length_crc8_frame_receiver_core.sv
// Frame receiver with two-byte sync hunt, length byte and crc-8 check.
// Input channel in_chan: each beat is a received byte (operation 0) or a
// one-millisecond tick (operation 1). Result channel out_chan: a good frame
// gives its payload bytes as a run with last on the final beat; a crc
// mismatch, a rejected length or a mid-frame timeout gives one status beat.
// Registers (first_sync, second_sync, max_length, timeout_ms) sit on the
// cfg_ APB port at byte addresses 0, 4, 8 and 12; write them while idle.
// After a payload byte the input is held off while the crc runs bit-serially
// over that byte; sync, length, check bytes and ticks start no such run.
// A status beat is presented the cycle after the beat that causes it. A good
// frame reads back from the payload ram a byte at a time: the read state
// fetches it, then the load state moves it into the output register once
// that register is free, and input beats wait until the readout is done.
// The output register holds a finished beat; a new input beat is taken only
// while that register is empty or being taken in the same cycle, so a stalled
// receiver holds off the input channel.
// Reset (rst_n low, synchronous) restores register defaults and the sync
// hunt. The payload ram is not cleared: a frame only reads what it wrote.
module sync_length_crc8_frame_receiver_core #(
  parameter int FRAME_STORE_DEPTH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  slcfr_in_if.sink           in_chan,
  slcfr_out_if.source        out_chan,
  input  logic               cfg_psel,
  input  logic               cfg_penable,
  input  logic               cfg_pwrite,
  input  logic [3:0]         cfg_paddr,
  input  logic [31:0]        cfg_pwdata,
  output logic [31:0]        cfg_prdata,
  output logic               cfg_pready
);
  import slcfr_pkg::*;

  localparam int AW = $clog2(FRAME_STORE_DEPTH);
  localparam logic [8:0] LEN_LIMIT = 9'(FRAME_STORE_DEPTH - 1);

  // sequencer states
  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_LD   = 2'd2;

  // configuration registers
  byte_t       first_sync_r, second_sync_r;
  len_t        max_length_r;
  logic [15:0] timeout_ms_r;

  // receiver state
  logic [1:0]  state_r, state_nxt;
  phase_t      phase_r, phase_nxt;
  len_t        frame_len_r, frame_len_nxt;
  len_t        count_r, count_nxt;
  len_t        rd_idx_r, rd_idx_nxt;
  logic [15:0] idle_ticks_r, idle_ticks_nxt;

  // output register
  logic        out_valid_r, out_valid_nxt;
  byte_t       out_byte_r, out_byte_nxt;
  len_t        out_idx_r, out_idx_nxt;
  logic        out_pv_r, out_pv_nxt;
  status_t     out_status_r, out_status_nxt;
  logic        out_last_r, out_last_nxt;

  // datapath helpers
  logic        cfg_wr;
  logic        in_fire, out_fire, out_free;
  byte_t       in_b;
  logic [15:0] ticks_inc;
  crc_ctrl_t   crc_ctrl;
  byte_t       crc_val;
  logic        crc_busy;
  logic        ram_we, ram_re;
  logic [8:0]  waddr_wide, raddr_wide;
  logic [AW-1:0] ram_waddr, ram_raddr;
  byte_t       ram_rdata;

  // configuration port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel & cfg_penable & cfg_pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      first_sync_r  <= FIRST_SYNC_RST;
      second_sync_r <= SECOND_SYNC_RST;
      max_length_r  <= MAX_LENGTH_RST;
      timeout_ms_r  <= TIMEOUT_MS_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        REG_FIRST_SYNC:  first_sync_r  <= cfg_pwdata[7:0];
        REG_SECOND_SYNC: second_sync_r <= cfg_pwdata[7:0];
        REG_MAX_LENGTH:  max_length_r  <= cfg_pwdata[5:0];
        REG_TIMEOUT_MS:  timeout_ms_r  <= cfg_pwdata[15:0];
      endcase
    end
  end

  // register read-back
  always_comb begin
    unique case (cfg_paddr[3:2])
      REG_FIRST_SYNC:  cfg_prdata = {24'd0, first_sync_r};
      REG_SECOND_SYNC: cfg_prdata = {24'd0, second_sync_r};
      REG_MAX_LENGTH:  cfg_prdata = {26'd0, max_length_r};
      REG_TIMEOUT_MS:  cfg_prdata = {16'd0, timeout_ms_r};
    endcase
  end

  // handshakes
  assign out_fire      = out_valid_r & out_chan.ready;
  assign out_free      = ~out_valid_r | out_chan.ready;
  assign in_chan.ready = (state_r == S_IDLE) & ~crc_busy & out_free;
  assign in_fire       = in_chan.valid & in_chan.ready;
  assign in_b          = in_chan.data_byte;
  assign ticks_inc     = (idle_ticks_r == TICKS_MAX) ? idle_ticks_r
                                                     : idle_ticks_r + 16'd1;

  // ram addressing, widened then cut to the store's address width
  assign waddr_wide = {3'd0, count_r};
  assign raddr_wide = {3'd0, rd_idx_r};
  assign ram_waddr  = waddr_wide[AW-1:0];
  assign ram_raddr  = raddr_wide[AW-1:0];

  // receiver and readout control
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    frame_len_nxt  = frame_len_r;
    count_nxt      = count_r;
    rd_idx_nxt     = rd_idx_r;
    idle_ticks_nxt = idle_ticks_r;
    out_valid_nxt  = out_fire ? 1'b0 : out_valid_r;
    out_byte_nxt   = out_byte_r;
    out_idx_nxt    = out_idx_r;
    out_pv_nxt     = out_pv_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    crc_ctrl       = '0;
    ram_we         = 1'b0;
    ram_re         = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          if (in_chan.operation) begin
            // tick: count idle time, drop a partial frame past the limit
            idle_ticks_nxt = ticks_inc;
            if (phase_r != PH_SYNC1 && ticks_inc > timeout_ms_r) begin
              phase_nxt      = PH_SYNC1;
              out_valid_nxt  = 1'b1;
              out_byte_nxt   = 8'd0;
              out_idx_nxt    = 6'd0;
              out_pv_nxt     = 1'b0;
              out_status_nxt = ST_TIMEOUT;
              out_last_nxt   = 1'b1;
            end
          end else begin
            idle_ticks_nxt = 16'd0;
            unique case (phase_r)
              PH_SYNC1: begin
                if (in_b == first_sync_r) phase_nxt = PH_SYNC2;
              end
              PH_SYNC2: begin
                // second sync wins when both registers match
                if (in_b == second_sync_r)     phase_nxt = PH_LEN;
                else if (in_b != first_sync_r) phase_nxt = PH_SYNC1;
              end
              PH_LEN: begin
                if ({1'b0, in_b} > {3'd0, max_length_r} || {1'b0, in_b} > LEN_LIMIT) begin
                  phase_nxt      = PH_SYNC1;
                  out_valid_nxt  = 1'b1;
                  out_byte_nxt   = 8'd0;
                  out_idx_nxt    = 6'd0;
                  out_pv_nxt     = 1'b0;
                  out_status_nxt = ST_LEN;
                  out_last_nxt   = 1'b1;
                end else begin
                  frame_len_nxt = in_b[5:0];
                  count_nxt     = 6'd0;
                  crc_ctrl.init = 1'b1;
                  phase_nxt     = PH_DATA;
                end
              end
              PH_DATA: begin
                if (count_r < frame_len_r) begin
                  // payload byte: store it and start the serial crc
                  ram_we         = 1'b1;
                  crc_ctrl.start = 1'b1;
                  count_nxt      = count_r + 6'd1;
                end else begin
                  // check byte
                  phase_nxt = PH_SYNC1;
                  if (crc_val != in_b || frame_len_r == 6'd0) begin
                    out_valid_nxt  = 1'b1;
                    out_byte_nxt   = 8'd0;
                    out_idx_nxt    = 6'd0;
                    out_pv_nxt     = 1'b0;
                    out_status_nxt = (crc_val != in_b) ? ST_CRC : ST_OK;
                    out_last_nxt   = 1'b1;
                  end else begin
                    rd_idx_nxt = 6'd0;
                    state_nxt  = S_RD;
                  end
                end
              end
            endcase
          end
        end
      end
      S_RD: begin
        // read one stored byte
        ram_re    = 1'b1;
        state_nxt = S_LD;
      end
      S_LD: begin
        // move it into the output register once that is free
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = ram_rdata;
          out_idx_nxt    = rd_idx_r;
          out_pv_nxt     = 1'b1;
          out_status_nxt = ST_OK;
          out_last_nxt   = (rd_idx_r == frame_len_r - 6'd1);
          if (rd_idx_r == frame_len_r - 6'd1) begin
            state_nxt = S_IDLE;
          end else begin
            rd_idx_nxt = rd_idx_r + 6'd1;
            state_nxt  = S_RD;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      phase_r      <= PH_SYNC1;
      frame_len_r  <= 6'd0;
      count_r      <= 6'd0;
      rd_idx_r     <= 6'd0;
      idle_ticks_r <= 16'd0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      phase_r      <= phase_nxt;
      frame_len_r  <= frame_len_nxt;
      count_r      <= count_nxt;
      rd_idx_r     <= rd_idx_nxt;
      idle_ticks_r <= idle_ticks_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // output payload register
  always_ff @(posedge clk) begin
    out_byte_r   <= out_byte_nxt;
    out_idx_r    <= out_idx_nxt;
    out_pv_r     <= out_pv_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

  assign out_chan.valid         = out_valid_r;
  assign out_chan.payload_byte  = out_byte_r;
  assign out_chan.byte_index    = out_idx_r;
  assign out_chan.payload_valid = out_pv_r;
  assign out_chan.frame_status  = out_status_r;
  assign out_chan.last          = out_last_r;

  // serial crc over the payload
  slcfr_crc8 u_crc (
    .clk   (clk),
    .rst_n (rst_n),
    .ctrl  (crc_ctrl),
    .data  (in_b),
    .crc   (crc_val),
    .busy  (crc_busy)
  );

  // payload store
  slcfr_ram #(
    .WIDTH (8),
    .DEPTH (FRAME_STORE_DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (in_b),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

endmodule

FILE: src/slcfr_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies
module slcfr_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read, held while re is low
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

FILE: src/slcfr_crc8.sv
// bit-serial crc-8 (poly 0x31), one bit step per cycle, eight steps per byte
// depends on slcfr_pkg
module slcfr_crc8 (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slcfr_pkg::crc_ctrl_t ctrl,
  input  slcfr_pkg::byte_t     data,
  output slcfr_pkg::byte_t     crc,
  output logic                 busy
);
  import slcfr_pkg::*;

  byte_t      crc_r, crc_nxt;
  logic [3:0] step_r, step_nxt;

  // shift register with feedback, bits left counted down in step_r
  always_comb begin
    crc_nxt  = crc_r;
    step_nxt = step_r;
    priority if (ctrl.init) begin
      crc_nxt  = CRC_INIT;
      step_nxt = 4'd0;
    end else if (ctrl.start) begin
      crc_nxt  = crc_r ^ data;
      step_nxt = 4'd8;
    end else if (step_r != 4'd0) begin
      crc_nxt  = {crc_r[6:0], 1'b0} ^ (crc_r[7] ? CRC_POLY : 8'h00);
      step_nxt = step_r - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r  <= CRC_INIT;
      step_r <= 4'd0;
    end else begin
      crc_r  <= crc_nxt;
      step_r <= step_nxt;
    end
  end

  assign crc  = crc_r;
  assign busy = (step_r != 4'd0);

endmodule

FILE: tb/slcfr_rx_checker.sv
// checker for the frame receiver: mirrors the registers, predicts result beats
// and compares them with the result channel in order
// depends on slcfr_pkg, slcfr_in_if and slcfr_out_if
module slcfr_rx_checker (
  input  logic        clk,
  input  logic        rst_n,
  slcfr_in_if         in_mon,
  slcfr_out_if        out_mon,
  input  logic        cfg_psel,
  input  logic        cfg_penable,
  input  logic        cfg_pwrite,
  input  logic        cfg_pready,
  input  logic [3:0]  cfg_paddr,
  input  logic [31:0] cfg_pwdata,
  output int          mismatches,
  output int          expected_left,
  output int          beats_checked
);
  import slcfr_pkg::*;

  localparam int STORE_DEPTH = 64;

  typedef struct packed {
    byte_t   payload_byte;
    len_t    byte_index;
    logic    payload_valid;
    status_t frame_status;
    logic    last;
  } rx_result_t;

  // register copies
  byte_t       sync_a;
  byte_t       sync_b;
  len_t        len_limit;
  logic [15:0] tick_limit;

  // receiver state copy
  phase_t      rx_phase;
  len_t        rx_len;
  logic [6:0]  rx_count;
  byte_t       rx_crc;
  byte_t       payload_mem [STORE_DEPTH];
  logic [15:0] tick_count;

  rx_result_t  result_q [$];
  int          err_cnt;
  int          checked_cnt;

  // crc-8, msb first, one byte folded in
  function automatic byte_t crc8_update(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  task automatic push_status(input status_t st);
    rx_result_t r;
    r.payload_byte  = '0;
    r.byte_index    = '0;
    r.payload_valid = 1'b0;
    r.frame_status  = st;
    r.last          = 1'b1;
    result_q.push_back(r);
  endtask

  // one accepted input beat: advance the state and queue what it releases
  task automatic predict_beat(input logic op, input byte_t b);
    rx_result_t r;
    int k;
    if (op) begin
      if (tick_count != TICKS_MAX) tick_count++;
      if (rx_phase != PH_SYNC1 && tick_count > tick_limit) begin
        rx_phase = PH_SYNC1;
        push_status(ST_TIMEOUT);
      end
    end else begin
      tick_count = '0;
      case (rx_phase)
        PH_SYNC1: begin
          if (b == sync_a) rx_phase = PH_SYNC2;
        end
        PH_SYNC2: begin
          // second sync is tested first, so it wins when both are equal
          if (b == sync_b) rx_phase = PH_LEN;
          else if (b != sync_a) rx_phase = PH_SYNC1;
        end
        PH_LEN: begin
          if (b > len_limit || b > STORE_DEPTH - 1) begin
            rx_phase = PH_SYNC1;
            push_status(ST_LEN);
          end else begin
            rx_len   = b[5:0];
            rx_count = '0;
            rx_crc   = CRC_INIT;
            rx_phase = PH_DATA;
          end
        end
        default: begin
          if (rx_count < rx_len) begin
            payload_mem[rx_count[5:0]] = b;
            rx_crc   = crc8_update(rx_crc, b);
            rx_count = rx_count + 7'd1;
          end else begin
            rx_count = rx_count + 7'd1;
            rx_phase = PH_SYNC1;
            if (rx_crc != b) begin
              push_status(ST_CRC);
            end else if (rx_len == 0) begin
              push_status(ST_OK);
            end else begin
              for (k = 0; k < rx_len; k++) begin
                r.payload_byte  = payload_mem[k];
                r.byte_index    = len_t'(k);
                r.payload_valid = 1'b1;
                r.frame_status  = ST_OK;
                r.last          = (k + 1 == rx_len);
                result_q.push_back(r);
              end
            end
          end
        end
      endcase
    end
  endtask

  // result beats first, then register writes, then the input beat
  always @(posedge clk) begin
    rx_result_t seen;
    rx_result_t want;
    if (!rst_n) begin
      sync_a     = FIRST_SYNC_RST;
      sync_b     = SECOND_SYNC_RST;
      len_limit  = MAX_LENGTH_RST;
      tick_limit = TIMEOUT_MS_RST;
      rx_phase   = PH_SYNC1;
      rx_len     = '0;
      rx_count   = '0;
      rx_crc     = CRC_INIT;
      tick_count = '0;
      result_q.delete();
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        seen.payload_byte  = out_mon.payload_byte;
        seen.byte_index    = out_mon.byte_index;
        seen.payload_valid = out_mon.payload_valid;
        seen.frame_status  = out_mon.frame_status;
        seen.last          = out_mon.last;
        checked_cnt++;
        if (result_q.size() == 0) begin
          err_cnt++;
          $display("%0t: unexpected result beat byte=%h idx=%0d pv=%b st=%0d last=%b",
                   $time, seen.payload_byte, seen.byte_index, seen.payload_valid,
                   seen.frame_status, seen.last);
        end else begin
          want = result_q.pop_front();
          if (seen !== want) begin
            err_cnt++;
            $display("%0t: result mismatch expected byte=%h idx=%0d pv=%b st=%0d last=%b",
                     $time, want.payload_byte, want.byte_index, want.payload_valid,
                     want.frame_status, want.last);
            $display("%0t:                 actual   byte=%h idx=%0d pv=%b st=%0d last=%b",
                     $time, seen.payload_byte, seen.byte_index, seen.payload_valid,
                     seen.frame_status, seen.last);
          end
        end
      end
      // register writes, masked to their widths
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
        case (reg_idx_t'(cfg_paddr[3:2]))
          REG_FIRST_SYNC:  sync_a     = cfg_pwdata[7:0];
          REG_SECOND_SYNC: sync_b     = cfg_pwdata[7:0];
          REG_MAX_LENGTH:  len_limit  = cfg_pwdata[5:0];
          REG_TIMEOUT_MS:  tick_limit = cfg_pwdata[15:0];
          default: ;
        endcase
      end
      if (in_mon.valid && in_mon.ready) predict_beat(in_mon.operation, in_mon.data_byte);
    end
    mismatches    <= err_cnt;
    expected_left <= result_q.size();
    beats_checked <= checked_cnt;
  end

endmodule

FILE: tb/sync_length_crc8_frame_receiver_core_tb.sv
// top of the frame receiver regression: clock, reset, stimulus, receiver stalls
// and verdict; prediction and comparison sit in slcfr_rx_checker
// depends on slcfr_pkg, both channel interfaces, the core and the checker
module sync_length_crc8_frame_receiver_core_tb;
  import slcfr_pkg::*;

  localparam int DRAIN_CYCLES = 24;
  localparam int HOLD_CYCLES  = 1000;
  localparam int QUIET_LIMIT  = 4000;
  localparam int PHASE_BEATS  = 16;

  logic        clk = 1'b0;
  logic        rst_n;
  logic        cfg_psel;
  logic        cfg_penable;
  logic        cfg_pwrite;
  logic [3:0]  cfg_paddr;
  logic [31:0] cfg_pwdata;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  int mismatches;
  int expected_left;
  int beats_checked;

  // stimulus side copies of the registers
  byte_t       cur_first;
  byte_t       cur_second;
  len_t        cur_max;
  logic [15:0] cur_tmo;

  int beats_sent;
  int frames_sent;
  int settings_used;
  int burst_left;
  bit no_gaps;
  bit hold_req;

  slcfr_in_if  in_chan ();
  slcfr_out_if out_chan ();

  sync_length_crc8_frame_receiver_core u_top (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  slcfr_rx_checker u_chk (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_mon        (in_chan),
    .out_mon       (out_chan),
    .cfg_psel      (cfg_psel),
    .cfg_penable   (cfg_penable),
    .cfg_pwrite    (cfg_pwrite),
    .cfg_pready    (cfg_pready),
    .cfg_paddr     (cfg_paddr),
    .cfg_pwdata    (cfg_pwdata),
    .mismatches    (mismatches),
    .expected_left (expected_left),
    .beats_checked (beats_checked)
  );

  always #1 clk = ~clk;

  // crc-8, msb first, one byte folded in, for building check bytes
  function automatic byte_t crc8_next(input byte_t crc, input byte_t b);
    byte_t c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    return c;
  endfunction

  // one input beat, with a random gap between bursts
  task automatic put_beat(input logic op, input byte_t b);
    int gap;
    logic taken;
    if (!no_gaps && burst_left == 0) begin
      gap = $urandom_range(1, 8);
      in_chan.valid <= 1'b0;
      repeat (gap) @(posedge clk);
      burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 80)
                                               : $urandom_range(1, 12);
    end
    if (burst_left > 0) burst_left--;
    in_chan.valid     <= 1'b1;
    in_chan.operation <= op;
    in_chan.data_byte <= b;
    do begin
      @(negedge clk);
      taken = in_chan.ready;
      @(posedge clk);
    end while (!taken);
    beats_sent++;
  endtask

  // sync, length, random payload and a good or corrupted check byte
  task automatic send_frame(input int len, input bit good);
    byte_t crc;
    byte_t b;
    put_beat(1'b0, cur_first);
    put_beat(1'b0, cur_second);
    put_beat(1'b0, byte_t'(len));
    crc = CRC_INIT;
    for (int i = 0; i < len; i++) begin
      b   = byte_t'($urandom);
      crc = crc8_next(crc, b);
      put_beat(1'b0, b);
    end
    put_beat(1'b0, good ? crc : crc ^ byte_t'($urandom_range(1, 255)));
    frames_sent++;
  endtask

  // a frame cut short, followed by a run of ticks
  task automatic send_cut_frame();
    int n;
    int ticks;
    put_beat(1'b0, cur_first);
    n = $urandom_range(0, 2);
    if (n > 0) put_beat(1'b0, cur_second);
    if (n > 1) begin
      put_beat(1'b0, byte_t'($urandom_range(0, cur_max)));
      repeat ($urandom_range(0, 3)) put_beat(1'b0, byte_t'($urandom));
    end
    ticks = (cur_tmo <= 12) ? cur_tmo + 1 + $urandom_range(0, 2) : $urandom_range(1, 10);
    repeat (ticks) put_beat(1'b1, byte_t'($urandom));
  endtask

  // apb write: setup, access, then back to idle
  task automatic write_reg(input reg_idx_t idx, input logic [31:0] val);
    logic done;
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do begin
      @(negedge clk);
      done = cfg_pready;
      @(posedge clk);
    end while (!done);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_FIRST_SYNC:  cur_first  = val[7:0];
      REG_SECOND_SYNC: cur_second = val[7:0];
      REG_MAX_LENGTH:  cur_max    = val[5:0];
      REG_TIMEOUT_MS:  cur_tmo    = val[15:0];
      default: ;
    endcase
  endtask

  // all four registers, with junk above each field
  task automatic write_all(input byte_t fs, input byte_t ss, input len_t ml,
                           input logic [15:0] tm);
    write_reg(REG_FIRST_SYNC,  {8'($urandom), 16'h0, fs});
    write_reg(REG_SECOND_SYNC, {24'($urandom), ss});
    write_reg(REG_MAX_LENGTH,  {26'($urandom), ml});
    write_reg(REG_TIMEOUT_MS,  {16'($urandom), tm});
    settings_used++;
  endtask

  // stop offering beats, wait for every expected result and the tail of the work
  task automatic settle();
    in_chan.valid <= 1'b0;
    burst_left = 0;
    do @(posedge clk); while (expected_left != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // receiver: a stall pattern of its own, plus one long hold-off on request
  initial begin : rx_stall
    int rx_cyc;
    rx_cyc = 0;
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      rx_cyc++;
      if (hold_req) begin
        hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else begin
        case ((rx_cyc / 173) % 4)
          0: out_chan.ready <= 1'b1;
          1: out_chan.ready <= ($urandom_range(0, 3) != 0);
          2: out_chan.ready <= ((rx_cyc % 5) < 2);
          default: out_chan.ready <= $urandom_range(0, 1);
        endcase
      end
    end
  end

  // watchdog: too long without any accepted beat or register access
  initial begin : watchdog
    int quiet;
    quiet = 0;
    while (quiet < QUIET_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready) || cfg_psel)
        quiet = 0;
      else
        quiet++;
    end
    $display("%0t: no beat accepted for %0d cycles", $time, QUIET_LIMIT);
    $display("sync_length_crc8_frame_receiver_core regression: fail");
    $finish;
  end

  // stimulus
  initial begin : stim
    int pick;
    int len;
    int lim;
    byte_t fs;
    byte_t ss;
    len_t ml;
    logic [15:0] tm;
    in_chan.valid     <= 1'b0;
    in_chan.operation <= 1'b0;
    in_chan.data_byte <= '0;
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= '0;
    cfg_pwdata  <= '0;
    rst_n       <= 1'b0;
    cur_first   = FIRST_SYNC_RST;
    cur_second  = SECOND_SYNC_RST;
    cur_max     = MAX_LENGTH_RST;
    cur_tmo     = TIMEOUT_MS_RST;
    beats_sent  = 0;
    frames_sent = 0;
    settings_used = 1;
    burst_left  = 0;
    no_gaps     = 1'b0;
    hold_req    = 1'b0;
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed, reset register values
    // repeated first sync, then payload bytes at both extremes
    put_beat(1'b0, cur_first);
    put_beat(1'b0, cur_first);
    put_beat(1'b0, cur_second);
    put_beat(1'b0, 8'd2);
    put_beat(1'b0, 8'h00);
    put_beat(1'b0, 8'hFF);
    put_beat(1'b0, crc8_next(crc8_next(CRC_INIT, 8'h00), 8'hFF));
    // zero-length frame
    send_frame(0, 1'b1);
    // length too large
    put_beat(1'b0, cur_first);
    put_beat(1'b0, cur_second);
    put_beat(1'b0, 8'hFF);
    // check byte mismatch
    send_frame(1, 1'b0);
    // broken sync, then a tick while hunting
    put_beat(1'b0, cur_first);
    put_beat(1'b0, 8'h00);
    put_beat(1'b1, 8'hFF);
    // timeout with a zero limit
    settle();
    write_reg(REG_TIMEOUT_MS, 32'h0);
    put_beat(1'b0, cur_first);
    put_beat(1'b1, 8'h00);

    // random phases, the first two at the register extremes
    for (int p = 0; p < 6; p++) begin
      settle();
      case (p)
        0: begin fs = 8'h00; ss = 8'hFF; ml = 6'd0;  tm = 16'h0000; end
        1: begin fs = 8'hFF; ss = 8'h00; ml = 6'd63; tm = 16'hFFFF; end
        default: begin
          case ($urandom_range(0, 3))
            0: fs = 8'h00;
            1: fs = 8'hFF;
            2: fs = FIRST_SYNC_RST;
            default: fs = byte_t'($urandom);
          endcase
          case ($urandom_range(0, 4))
            0: ss = fs;
            1: ss = 8'h00;
            2: ss = 8'hFF;
            default: ss = byte_t'($urandom);
          endcase
          case ($urandom_range(0, 3))
            0: ml = 6'd63;
            1: ml = 6'd4;
            default: ml = len_t'($urandom_range(1, 62));
          endcase
          case ($urandom_range(0, 4))
            0: tm = 16'd1;
            1: tm = 16'($urandom_range(2, 8));
            2: tm = 16'($urandom);
            3: tm = 16'hFFFF;
            default: tm = 16'd0;
          endcase
        end
      endcase
      write_all(fs, ss, ml, tm);
      lim = beats_sent + PHASE_BEATS;
      while (beats_sent < lim) begin
        pick = $urandom_range(0, 99);
        if (pick < 55) begin
          len = ($urandom_range(0, 7) == 0) ? cur_max
                                            : $urandom_range(0, (cur_max < 8) ? cur_max : 8);
          send_frame(len, 1'b1);
        end else if (pick < 67) begin
          send_frame($urandom_range(0, (cur_max < 6) ? cur_max : 6), 1'b0);
        end else if (pick < 75) begin
          put_beat(1'b0, cur_first);
          put_beat(1'b0, cur_second);
          put_beat(1'b0, byte_t'($urandom_range(cur_max + 1, 255)));
        end else if (pick < 85) begin
          send_cut_frame();
        end else if (pick < 92) begin
          put_beat(1'b0, cur_first);
          put_beat(1'b0, byte_t'($urandom));
        end else begin
          repeat ($urandom_range(1, 4)) put_beat(1'(($urandom_range(0, 1))), byte_t'($urandom));
        end
      end
    end

    // long receiver hold-off while a full-length frame and a shorter one keep coming
    settle();
    write_all(FIRST_SYNC_RST, SECOND_SYNC_RST, 6'd63, 16'hFFFF);
    no_gaps  = 1'b1;
    hold_req = 1'b1;
    send_frame(63, 1'b1);
    send_frame(20, 1'b1);
    no_gaps  = 1'b0;

    settle();
    $display("run covered %0d input beats, %0d sent frames, %0d register settings",
             beats_sent, frames_sent, settings_used);
    $display("%0d result beats checked, %0d mismatches", beats_checked, mismatches);
    if (mismatches == 0 && expected_left == 0)
      $display("sync_length_crc8_frame_receiver_core regression: pass");
    else
      $display("sync_length_crc8_frame_receiver_core regression: fail");
    $finish;
  end

endmodule

FILE: filelist.f
src/slcfr_pkg.sv
src/slcfr_in_if.sv
src/slcfr_out_if.sv
src/slcfr_ram.sv
src/slcfr_crc8.sv
src/sync_length_crc8_frame_receiver_core.sv
tb/slcfr_rx_checker.sv
tb/sync_length_crc8_frame_receiver_core_tb.sv
